// File: sv/dffp_pkg.sv
// Shared types and constants for the delimited frame field parser.
// Used by dffp_front, dffp_back and delimited_frame_field_parser.
// No dependencies.
package dffp_pkg;

  localparam int MAX_FIELDS  = 16;
  localparam int FIELD_BYTES = 128;

  localparam int FIELD_IDX_W = $clog2(MAX_FIELDS);
  localparam int POS_W       = $clog2(FIELD_BYTES);
  localparam int BYTE_IDX_W  = 8;
  localparam int ADDR_W      = 1 + FIELD_IDX_W + POS_W;
  localparam int MARK_IDX_W  = 1 + FIELD_IDX_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_START = 8'h73;
  localparam logic [7:0] CH_END   = 8'h65;
  localparam logic [7:0] CH_SEP   = 8'h2C;
  localparam logic [7:0] CH_CMD   = 8'h70;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] KIND_LINE     = 2'd1;
  localparam logic [1:0] KIND_CROSSING = 2'd2;
  localparam logic [1:0] KIND_COMMAND  = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Command classes produced by the front end.
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_END   = 3'd1;
  localparam logic [2:0] CMD_SEP   = 3'd2;
  localparam logic [2:0] CMD_DATA  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [7:0] field_select;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_value;
    logic [1:0] frame_kind;
    logic [4:0] field_total;
    logic [7:0] frame_tail_length;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: sv/dffp_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on dffp_pkg.
module dffp_front
  import dffp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t              buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              new_cmd;
  logic              do_push, do_pop;

  always_comb begin
    new_cmd.data = in_item.rx_byte;
    if (in_item.opcode == OP_READ) begin
      new_cmd.kind = CMD_READ;
      new_cmd.data = in_item.field_select;
    end else if (in_item.rx_byte == CH_START) begin
      new_cmd.kind = CMD_START;
    end else if (in_item.rx_byte == CH_END) begin
      new_cmd.kind = CMD_END;
    end else if (in_item.rx_byte == CH_SEP) begin
      new_cmd.kind = CMD_SEP;
    end else begin
      new_cmd.kind = CMD_DATA;
    end
  end

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = buf_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// File: sv/dffp_back.sv
// Back end: carries out queued commands, holds frame state and the byte banks,
// walks a committed field for reads and holds the result register.
// Depends on dffp_pkg.
module dffp_back
  import dffp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [BYTE_IDX_W-1:0] FULL_LEN = BYTE_IDX_W'(FIELD_BYTES);

  logic [1:0]             state_r, state_nxt;
  logic                   receiving_r, receiving_nxt;
  logic                   type_pending_r, type_pending_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [FIELD_IDX_W-1:0] fi_r, fi_nxt;
  logic [BYTE_IDX_W-1:0]  bi_r, bi_nxt;
  logic [4:0]             count_r, count_nxt;
  logic [BYTE_IDX_W-1:0]  tail_r, tail_nxt;
  logic                   bank_r, bank_nxt;
  logic [FIELD_IDX_W-1:0] sel_r, sel_nxt;
  logic [BYTE_IDX_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_IDX_W-1:0]  len_r, len_nxt;
  logic [BYTE_IDX_W-1:0]  mark_cur_r, mark_cur_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic [7:0]             val_r, val_nxt;
  logic                   res_valid_r, res_valid_nxt;
  out_item_t              res_r;

  logic [BYTE_IDX_W-1:0]  len_tab_r [MAX_FIELDS];
  logic [BYTE_IDX_W-1:0]  mark_r [2*MAX_FIELDS];
  logic [7:0]             mem [2**ADDR_W];
  logic [7:0]             mem_q;

  logic                   len_we, mark_we, mark_clr, mem_we, mem_re, res_load;
  logic [BYTE_IDX_W-1:0]  mark_wdata, bi_inc, tab_val;
  logic [MARK_IDX_W-1:0]  wr_mark_idx, rd_mark_idx;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [7:0]             cur_byte, digit, sum_step;
  logic                   slot_free;

  assign slot_free   = !res_valid_r || pop;
  assign wr_mark_idx = {bank_r, fi_r};
  assign mem_waddr   = {bank_r, fi_r, bi_r[POS_W-1:0]};
  assign mem_raddr   = {~bank_r, sel_r, pos_r[POS_W-1:0]};
  assign bi_inc      = bi_r + 1'b1;
  assign cur_byte    = (pos_r < mark_cur_r) ? mem_q : 8'h00;
  assign digit       = cur_byte - CH_ZERO;
  assign sum_step    = (sum_r << 3) + (sum_r << 1) + digit;
  assign empty       = !res_valid_r;
  assign out_item    = res_r;

  always_comb begin
    state_nxt        = state_r;
    receiving_nxt    = receiving_r;
    type_pending_nxt = type_pending_r;
    kind_nxt         = kind_r;
    fi_nxt           = fi_r;
    bi_nxt           = bi_r;
    count_nxt        = count_r;
    tail_nxt         = tail_r;
    bank_nxt         = bank_r;
    sel_nxt          = sel_r;
    pos_nxt          = pos_r;
    len_nxt          = len_r;
    mark_cur_nxt     = mark_cur_r;
    sum_nxt          = sum_r;
    val_nxt          = val_r;
    res_valid_nxt    = res_valid_r && !pop;
    cmd_pop          = 1'b0;
    len_we           = 1'b0;
    mark_we          = 1'b0;
    mark_clr         = 1'b0;
    mark_wdata       = bi_inc;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    res_load         = 1'b0;
    rd_mark_idx      = {~bank_r, cmd.data[FIELD_IDX_W-1:0]};
    tab_val          = len_tab_r[cmd.data[FIELD_IDX_W-1:0]];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_START: begin
              receiving_nxt    = 1'b1;
              type_pending_nxt = 1'b1;
              fi_nxt           = '0;
              bi_nxt           = '0;
            end
            CMD_END: begin
              len_we        = 1'b1;
              receiving_nxt = 1'b0;
              tail_nxt      = bi_r;
              count_nxt     = {1'b0, fi_r} + 5'd1;
              fi_nxt        = '0;
              bi_nxt        = '0;
              bank_nxt      = ~bank_r;
              // The old committed bank becomes the working bank: forget its contents.
              mark_clr      = 1'b1;
            end
            CMD_SEP: begin
              len_we = 1'b1;
              if (fi_r != FIELD_IDX_W'(MAX_FIELDS - 1)) begin
                fi_nxt = fi_r + 1'b1;
              end
              bi_nxt = '0;
            end
            CMD_DATA: begin
              if (type_pending_r) begin
                if (cmd.data == CH_ONE) begin
                  kind_nxt = KIND_LINE;
                end else if (cmd.data == CH_TWO) begin
                  kind_nxt = KIND_CROSSING;
                end else if (cmd.data == CH_CMD) begin
                  kind_nxt = KIND_COMMAND;
                end
                type_pending_nxt = 1'b0;
              end
              if (receiving_r && (bi_r < FULL_LEN)) begin
                mem_we = 1'b1;
                bi_nxt = bi_inc;
                if (mark_r[wr_mark_idx] < bi_inc) begin
                  mark_we = 1'b1;
                end
              end
            end
            CMD_READ: begin
              sel_nxt      = cmd.data[FIELD_IDX_W-1:0];
              pos_nxt      = '0;
              sum_nxt      = '0;
              len_nxt      = (tab_val > FULL_LEN) ? FULL_LEN : tab_val;
              mark_cur_nxt = mark_r[rd_mark_idx];
              val_nxt      = '0;
              if ((cmd.data > {3'b000, count_r}) ||
                  (cmd.data > 8'(MAX_FIELDS - 1)) || (tab_val == '0)) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_ADDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADDR: begin
        mem_re    = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        if ((cur_byte < CH_ZERO) || (cur_byte > CH_NINE)) begin
          val_nxt   = cur_byte;
          state_nxt = S_EMIT;
        end else if (pos_r + 1'b1 == len_r) begin
          val_nxt   = sum_step;
          state_nxt = S_EMIT;
        end else begin
          sum_nxt   = sum_step;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          res_load      = 1'b1;
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      receiving_r    <= 1'b0;
      type_pending_r <= 1'b0;
      kind_r         <= '0;
      fi_r           <= '0;
      bi_r           <= '0;
      count_r        <= '0;
      tail_r         <= '0;
      bank_r         <= 1'b0;
      res_valid_r    <= 1'b0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        len_tab_r[i] <= '0;
      end
      for (int i = 0; i < 2*MAX_FIELDS; i++) begin
        mark_r[i] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      receiving_r    <= receiving_nxt;
      type_pending_r <= type_pending_nxt;
      kind_r         <= kind_nxt;
      fi_r           <= fi_nxt;
      bi_r           <= bi_nxt;
      count_r        <= count_nxt;
      tail_r         <= tail_nxt;
      bank_r         <= bank_nxt;
      res_valid_r    <= res_valid_nxt;
      if (len_we) begin
        len_tab_r[fi_r] <= bi_r;
      end
      if (mark_we) begin
        mark_r[wr_mark_idx] <= mark_wdata;
      end
      if (mark_clr) begin
        for (int i = 0; i < MAX_FIELDS; i++) begin
          mark_r[{~bank_r, FIELD_IDX_W'(i)}] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    mark_cur_r <= mark_cur_nxt;
    sum_r      <= sum_nxt;
    val_r      <= val_nxt;
    if (res_load) begin
      res_r.field_value       <= val_r;
      res_r.frame_kind        <= kind_r;
      res_r.field_total       <= count_r;
      res_r.frame_tail_length <= tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.data;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

endmodule

// File: sv/delimited_frame_field_parser.sv
// Top level of the delimited frame field parser: front end, command queue and back end.
// Depends on dffp_pkg, dffp_front and dffp_back.
//
//   Channel   Handshake          Payload
//   input     push / full        in_item  (opcode, rx_byte, field_select)
//   result    empty / pop        out_item (field_value, frame_kind, field_total,
//                                          frame_tail_length)
//
// A received byte is handled by the back end once it reaches the head of the four-entry queue.
// A read that ends at once (out of range or empty field) goes straight to its emit state;
// otherwise it walks the field byte by byte through an address state and a data state
// per byte until a stop, as the byte bank has a registered read.
// Synchronous active-low reset empties the queue, the result register and the frame state.
// Input is taken while the queue has room. A result waiting in the output register holds
// the next read in its last cycle, and items behind that read wait in the queue.
module delimited_frame_field_parser
  import dffp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  dffp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  dffp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
